### design/rfb_pkg.sv
// rfb_pkg: widths, register indexes and reset values of the radial feather block.
// No dependencies; imported by radial_feather_brighten and rfb_checker.
package rfb_pkg;

  // Pixel coordinate width and gain fraction bits
  localparam int COORD_BITS     = 12;
  localparam int GAIN_FRAC_BITS = 24;

  // Configuration register widths
  localparam int FRAME_W = 13;
  localparam int RATIO_W = 17;
  localparam int GAIN_W  = 32;
  localparam int CHAN_W  = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1,
    REG_ASPECT_RATIO = 4'd2,
    REG_GAIN         = 4'd3
  } cfg_reg_e;

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [RATIO_W-1:0] ASPECT_RATIO_RST = 17'd49152;
  localparam logic [GAIN_W-1:0]  GAIN_RST         = 32'd35652;

  // Datapath widths, all derived
  localparam int CTR_W      = FRAME_W - 1;
  localparam int DIFF_W     = (COORD_BITS > CTR_W) ? COORD_BITS : CTR_W;
  localparam int SCALED_W   = DIFF_W + RATIO_W;
  localparam int SQ_W       = 2 * SCALED_W;
  localparam int SQ_HI_W    = SQ_W - 32;
  localparam int OTHER_SQ_W = 2 * DIFF_W;
  localparam int DIST_W     = ((SQ_HI_W > OTHER_SQ_W) ? SQ_HI_W : OTHER_SQ_W) + 1;
  localparam int PROD_W     = DIST_W + GAIN_W;
  localparam int AMT_W      = PROD_W - GAIN_FRAC_BITS;

  // Pipeline depth
  localparam int NUM_STAGES = 6;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pix_t;

endpackage

### design/radial_feather_brighten.sv
// radial_feather_brighten: six-stage pipelined radial brightening of one RGB pixel.
// Depends on rfb_pkg for widths, register indexes and reset values.

// The block takes one pixel per clock and returns one pixel per clock unless the
// output stalls. Each pixel passes six register stages (offset, scale of the long
// axis and square of the short axis, square of the scaled offset, distance sum, gain
// multiply, saturating add). Every stage holds its own valid bit; a stage takes new
// data whenever it is empty or its successor moves, so back-pressure on the output
// fills the bubbles first and in_ready_o drops only when all six stages hold a
// pixel. The configuration port is always ready and takes one register write per
// cycle; registers are meant to be written between frames.
module radial_feather_brighten
  import rfb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic [CHAN_W-1:0]     in_blue_i,
  input  logic [CHAN_W-1:0]     in_green_i,
  input  logic [CHAN_W-1:0]     in_red_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CHAN_W-1:0]     out_blue_o,
  output logic [CHAN_W-1:0]     out_green_o,
  output logic [CHAN_W-1:0]     out_red_o
);

  // Configuration registers
  logic [FRAME_W-1:0] frame_width_q;
  logic [FRAME_W-1:0] frame_height_q;
  logic [RATIO_W-1:0] aspect_ratio_q;
  logic [GAIN_W-1:0]  gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      aspect_ratio_q <= ASPECT_RATIO_RST;
      gain_q         <= GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FRAME_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FRAME_W-1:0];
        REG_ASPECT_RATIO: aspect_ratio_q <= cfg_data_i[RATIO_W-1:0];
        REG_GAIN:         gain_q         <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage control: a stage loads when empty or when its successor advances
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES:0]   adv;

  always_comb begin
    adv[NUM_STAGES] = out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Stage 1: offsets from the centre, pick the axis to scale
  logic [DIFF_W-1:0] pos_x_ext, pos_y_ext, ctr_x, ctr_y, adx, ady;
  logic              long_is_x;
  logic [DIFF_W-1:0] s1_long_d, s1_long_q, s1_other_d, s1_other_q;
  pix_t              s1_pix_q;

  always_comb begin
    pos_x_ext  = DIFF_W'(pos_x_i);
    pos_y_ext  = DIFF_W'(pos_y_i);
    ctr_x      = DIFF_W'(frame_width_q[FRAME_W-1:1]);
    ctr_y      = DIFF_W'(frame_height_q[FRAME_W-1:1]);
    adx        = (ctr_x > pos_x_ext) ? ctr_x - pos_x_ext : pos_x_ext - ctr_x;
    ady        = (ctr_y > pos_y_ext) ? ctr_y - pos_y_ext : pos_y_ext - ctr_y;
    // Equal sides scale the vertical offset
    long_is_x  = frame_width_q > frame_height_q;
    s1_long_d  = long_is_x ? adx : ady;
    s1_other_d = long_is_x ? ady : adx;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_long_q  <= s1_long_d;
      s1_other_q <= s1_other_d;
      s1_pix_q   <= '{blue: in_blue_i, green: in_green_i, red: in_red_i};
    end
  end

  // Stage 2: scale the long-axis offset (Q.16), square the other one
  logic [SCALED_W-1:0]   s2_scaled_q;
  logic [OTHER_SQ_W-1:0] s2_other_sq_q;
  pix_t                  s2_pix_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_scaled_q   <= SCALED_W'(s1_long_q) * SCALED_W'(aspect_ratio_q);
      s2_other_sq_q <= OTHER_SQ_W'(s1_other_q) * OTHER_SQ_W'(s1_other_q);
      s2_pix_q      <= s1_pix_q;
    end
  end

  // Stage 3: square the scaled offset, drop the 32 fraction bits
  logic [SQ_W-1:0]       sq_full;
  logic [SQ_HI_W-1:0]    s3_sq_hi_q;
  logic [OTHER_SQ_W-1:0] s3_other_sq_q;
  pix_t                  s3_pix_q;

  assign sq_full = SQ_W'(s2_scaled_q) * SQ_W'(s2_scaled_q);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_sq_hi_q    <= sq_full[SQ_W-1:32];
      s3_other_sq_q <= s2_other_sq_q;
      s3_pix_q      <= s2_pix_q;
    end
  end

  // Stage 4: squared distance
  logic [DIST_W-1:0] s4_dist_q;
  pix_t              s4_pix_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_dist_q <= DIST_W'(s3_sq_hi_q) + DIST_W'(s3_other_sq_q);
      s4_pix_q  <= s3_pix_q;
    end
  end

  // Stage 5: apply the gain
  logic [PROD_W-1:0] s5_prod_q;
  pix_t              s5_pix_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s5_prod_q <= PROD_W'(s4_dist_q) * PROD_W'(gain_q);
      s5_pix_q  <= s4_pix_q;
    end
  end

  // Stage 6: integer part of the gain product, saturating add per channel
  logic [AMT_W-1:0]  amt_wide;
  logic [CHAN_W-1:0] amt;
  logic [CHAN_W:0]   sum_b, sum_g, sum_r;
  pix_t              out_pix_d, out_pix_q;

  always_comb begin
    amt_wide = s5_prod_q[PROD_W-1:GAIN_FRAC_BITS];
    amt      = (amt_wide > AMT_W'({CHAN_W{1'b1}})) ? {CHAN_W{1'b1}} : amt_wide[CHAN_W-1:0];
    sum_b    = {1'b0, s5_pix_q.blue}  + {1'b0, amt};
    sum_g    = {1'b0, s5_pix_q.green} + {1'b0, amt};
    sum_r    = {1'b0, s5_pix_q.red}   + {1'b0, amt};
    out_pix_d.blue  = sum_b[CHAN_W] ? {CHAN_W{1'b1}} : sum_b[CHAN_W-1:0];
    out_pix_d.green = sum_g[CHAN_W] ? {CHAN_W{1'b1}} : sum_g[CHAN_W-1:0];
    out_pix_d.red   = sum_r[CHAN_W] ? {CHAN_W{1'b1}} : sum_r[CHAN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      out_pix_q <= out_pix_d;
    end
  end

  assign out_blue_o  = out_pix_q.blue;
  assign out_green_o = out_pix_q.green;
  assign out_red_o   = out_pix_q.red;

endmodule

### design/rfb_checker.sv
// rfb_checker: port-level assertions for radial_feather_brighten, bound to the top.
// Depends on rfb_pkg for channel widths.
module rfb_checker
  import rfb_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CHAN_W-1:0] out_blue_o,
  input logic [CHAN_W-1:0] out_green_o,
  input logic [CHAN_W-1:0] out_red_o
);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(out_blue_o) && $stable(out_green_o) && $stable(out_red_o))
    else $error("output payload changed while stalled");

  // Input is refused only when a result waits and is not taken
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused without output back-pressure");

  // Nothing is offered while in reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind radial_feather_brighten rfb_checker u_rfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_blue_o  (out_blue_o),
  .out_green_o (out_green_o),
  .out_red_o   (out_red_o)
);
